// ----- sv/psts_pkg.sv -----
// shared types, widths and codes for the pixel strip timed shifter
`default_nettype none

package psts_pkg;

  // field and register widths
  localparam int CMD_W     = 3;
  localparam int INDEX_W   = 10;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int AMOUNT_W  = 8;
  localparam int PERIOD_W  = 16;
  localparam int BPP_W     = 3;
  localparam int PCOUNT_W  = 9;
  localparam int TICK_W    = 17;
  // product of pixel count and bytes per pixel
  localparam int PROD_W    = 12;
  // span field wide enough for the largest store the parameters allow
  localparam int SPAN_W    = 15;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_DURATION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_FORWARDS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BPP           = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT   = 3'd6;

  // configuration reset values
  localparam logic [AMOUNT_W-1:0] RST_SHIFT_AMOUNT = 8'd1;
  localparam logic [PERIOD_W-1:0] RST_SHIFT_PERIOD = 16'd100;
  localparam logic [PERIOD_W-1:0] RST_RUN_DURATION = 16'd0;
  localparam logic [BPP_W-1:0]    RST_BPP          = 3'd3;
  localparam logic [PCOUNT_W-1:0] RST_PIXEL_COUNT  = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_PREP,
    ST_SHIFT
  } state_t;

  // control broadcast to every cell of the byte row
  typedef struct packed {
    logic              en;
    logic              go_left;
    logic [SPAN_W-1:0] span;
    logic [BYTE_W-1:0] tail;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- sv/psts_cell.sv -----
// one byte cell of the pixel row, moving its byte to a neighbor on command
`default_nettype none

module psts_cell #(
  parameter int IDX = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire psts_pkg::cell_ctl_t         ctl,
  input  wire logic [psts_pkg::BYTE_W-1:0] from_left,
  input  wire logic [psts_pkg::BYTE_W-1:0] from_right,
  output logic      [psts_pkg::BYTE_W-1:0] q
);
  import psts_pkg::*;

  logic [BYTE_W-1:0] q_r;
  logic [BYTE_W-1:0] q_nxt;
  logic              in_span;
  logic              is_tail;

  // position of this cell relative to the active span
  assign in_span = SPAN_W'(IDX) < ctl.span;
  assign is_tail = SPAN_W'(IDX + 1) == ctl.span;

  // take the neighbor byte, or, moving left, the tail byte at the span end
  always_comb begin
    q_nxt = q_r;
    if (ctl.en && in_span) begin
      if (ctl.go_left) begin
        q_nxt = is_tail ? ctl.tail : from_right;
      end else begin
        q_nxt = from_left;
      end
    end
  end

  // store byte, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- sv/psts_ctrl.sv -----
// sequencer, timers and configuration registers of the pixel strip shifter
`default_nettype none

module psts_ctrl #(
  parameter int MAX_PIXELS          = 256,
  parameter int MAX_BYTES_PER_PIXEL = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [psts_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [psts_pkg::INDEX_W-1:0]   in_byte_index,
  input  wire logic [psts_pkg::BYTE_W-1:0]    in_byte_value,
  output logic                                out_valid,
  output logic      [psts_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                                out_is_animating,
  output logic                                out_did_shift,
  output logic                                out_bad_amount,
  input  wire logic                           cfg_we,
  input  wire logic [psts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [psts_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [psts_pkg::BYTE_W-1:0]    head,
  output psts_pkg::cell_ctl_t                 ctl
);
  import psts_pkg::*;

  localparam int StoreBytes = MAX_PIXELS * MAX_BYTES_PER_PIXEL;
  localparam int SPW        = $clog2(StoreBytes + 1);
  localparam int CMPW       = (SPW > INDEX_W) ? SPW : INDEX_W;

  // configuration
  logic [AMOUNT_W-1:0] shift_amount_r;
  logic [PERIOD_W-1:0] shift_period_r;
  logic [PERIOD_W-1:0] run_duration_r;
  logic                wrap_mode_r;
  logic                move_forwards_r;
  logic [BPP_W-1:0]    bpp_r;
  logic [PCOUNT_W-1:0] pixel_count_r;

  // animation status
  state_t            state_r, state_nxt;
  logic              animating_r, animating_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0] tsince_r, tsince_nxt;
  logic              first_r, first_nxt;

  // sequencer data
  logic [SPW-1:0]     step_r;
  logic [SPW-1:0]     n_r;
  logic [INDEX_W-1:0] idx_r;
  logic [BYTE_W-1:0]  val_r;
  logic               wr_r;
  logic [BYTE_W-1:0]  rd_r;

  // result registers
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_read_byte_r;
  logic              out_is_animating_r;
  logic              out_did_shift_r;
  logic              out_bad_amount_r;

  logic              accept;
  logic              idx_ok;
  logic [TICK_W-1:0] elapsed_inc;
  logic [TICK_W-1:0] tsince_inc;
  logic              expire;
  logic              due;
  logic [PCOUNT_W-1:0] pcount_eff;
  logic [BPP_W-1:0]  bpp_eff;
  logic              amt_bad;
  logic              tick_shift;
  logic              tick_bad;
  logic [PROD_W-1:0] n_raw;
  logic [PROD_W-1:0] k_raw;
  logic [SPW-1:0]    n_eff;
  logic [SPW-1:0]    k_eff;
  logic [SPW-1:0]    steps;
  logic              hit;
  logic              last_step;
  logic              fire;
  logic [BYTE_W-1:0] res_rd;
  logic              res_anim;
  logic              res_shift;
  logic              res_bad;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);
  assign idx_ok = 32'(in_byte_index) < StoreBytes;

  // tick counters and shift decision
  assign elapsed_inc = (elapsed_r < TICK_MAX) ? elapsed_r + TICK_W'(1) : TICK_MAX;
  assign tsince_inc  = (tsince_r < TICK_MAX) ? tsince_r + TICK_W'(1) : TICK_MAX;
  assign expire      = (run_duration_r != '0) &&
                       (elapsed_inc > TICK_W'(run_duration_r));
  assign due         = first_r || (tsince_inc > TICK_W'(shift_period_r));
  assign pcount_eff  = (32'(pixel_count_r) > MAX_PIXELS) ?
                       PCOUNT_W'(MAX_PIXELS) : pixel_count_r;
  assign bpp_eff     = (32'(bpp_r) > MAX_BYTES_PER_PIXEL) ?
                       BPP_W'(MAX_BYTES_PER_PIXEL) : bpp_r;
  assign amt_bad     = (shift_amount_r == '0) ||
                       (PCOUNT_W'(shift_amount_r) > pcount_eff);
  assign tick_shift  = animating_r && !expire && due && !amt_bad;
  assign tick_bad    = animating_r && !expire && due && amt_bad;

  // strip span and step count of a shift
  assign n_raw = PROD_W'(pcount_eff) * PROD_W'(bpp_eff);
  assign k_raw = PROD_W'(shift_amount_r) * PROD_W'(bpp_eff);
  assign n_eff = (32'(n_raw) > StoreBytes) ? SPW'(StoreBytes) : SPW'(n_raw);
  assign k_eff = SPW'(k_raw);
  assign steps = (move_forwards_r && wrap_mode_r) ? n_eff - k_eff : k_eff;

  // byte access position
  assign hit       = CMPW'(step_r) == CMPW'(idx_r);
  assign last_step = step_r == SPW'(StoreBytes - 1);

  // animation status update on an accepted transaction
  always_comb begin
    animating_nxt = animating_r;
    elapsed_nxt   = elapsed_r;
    tsince_nxt    = tsince_r;
    first_nxt     = first_r;
    if (accept) begin
      case (in_cmd)
        CMD_START: begin
          animating_nxt = 1'b1;
          elapsed_nxt   = '0;
          tsince_nxt    = '0;
          first_nxt     = 1'b1;
        end
        CMD_STOP: begin
          animating_nxt = 1'b0;
        end
        CMD_TICK: begin
          if (animating_r) begin
            elapsed_nxt = elapsed_inc;
            if (expire) begin
              animating_nxt = 1'b0;
            end else if (due) begin
              tsince_nxt = '0;
              first_nxt  = 1'b0;
            end else begin
              tsince_nxt = tsince_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_WRITE, CMD_READ: begin
              if (idx_ok) begin
                state_nxt = ST_ACCESS;
              end
            end
            CMD_TICK: begin
              if (tick_shift) begin
                state_nxt = ST_PREP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ACCESS: begin
        if (last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PREP: begin
        state_nxt = (steps == '0) ? ST_IDLE : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (step_r == SPW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // cell row control and result values
  always_comb begin
    ctl       = '0;
    fire      = 1'b0;
    res_rd    = '0;
    res_anim  = animating_nxt;
    res_shift = 1'b0;
    res_bad   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_WRITE, CMD_READ: begin
              fire = !idx_ok;
            end
            CMD_TICK: begin
              fire    = !tick_shift;
              res_bad = tick_bad;
            end
            default: begin
              fire = 1'b1;
            end
          endcase
        end
      end
      ST_ACCESS: begin
        // full rotation of the row, the addressed byte passes the head
        ctl.en      = 1'b1;
        ctl.go_left = 1'b1;
        ctl.span    = SPAN_W'(StoreBytes);
        ctl.tail    = (wr_r && hit) ? val_r : head;
        fire        = last_step;
        res_rd      = wr_r ? '0 : (hit ? head : rd_r);
      end
      ST_PREP: begin
        fire      = (steps == '0);
        res_shift = 1'b1;
      end
      ST_SHIFT: begin
        // one byte position per cycle within the strip span
        ctl.en      = 1'b1;
        ctl.go_left = !(move_forwards_r && !wrap_mode_r);
        ctl.span    = SPAN_W'(n_r);
        ctl.tail    = wrap_mode_r ? head : '0;
        fire        = (step_r == SPW'(1));
        res_shift   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      animating_r     <= 1'b0;
      elapsed_r       <= '0;
      tsince_r        <= '0;
      first_r         <= 1'b1;
      shift_amount_r  <= RST_SHIFT_AMOUNT;
      shift_period_r  <= RST_SHIFT_PERIOD;
      run_duration_r  <= RST_RUN_DURATION;
      wrap_mode_r     <= 1'b1;
      move_forwards_r <= 1'b1;
      bpp_r           <= RST_BPP;
      pixel_count_r   <= RST_PIXEL_COUNT;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      animating_r <= animating_nxt;
      elapsed_r   <= elapsed_nxt;
      tsince_r    <= tsince_nxt;
      first_r     <= first_nxt;
      out_valid_r <= fire;

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SHIFT_AMOUNT:  shift_amount_r  <= cfg_data[AMOUNT_W-1:0];
          REG_SHIFT_PERIOD:  shift_period_r  <= cfg_data[PERIOD_W-1:0];
          REG_RUN_DURATION:  run_duration_r  <= cfg_data[PERIOD_W-1:0];
          REG_WRAP_MODE:     wrap_mode_r     <= cfg_data[0];
          REG_MOVE_FORWARDS: move_forwards_r <= cfg_data[0];
          REG_BPP:           bpp_r           <= cfg_data[BPP_W-1:0];
          REG_PIXEL_COUNT:   pixel_count_r   <= cfg_data[PCOUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // sequencer data and result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_byte_r    <= res_rd;
      out_is_animating_r <= res_anim;
      out_did_shift_r    <= res_shift;
      out_bad_amount_r   <= res_bad;
    end
    if (accept) begin
      idx_r  <= in_byte_index;
      val_r  <= in_byte_value;
      wr_r   <= (in_cmd == CMD_WRITE);
      rd_r   <= '0;
      step_r <= '0;
    end else begin
      case (state_r)
        ST_ACCESS: begin
          if (hit && !wr_r) begin
            rd_r <= head;
          end
          step_r <= step_r + SPW'(1);
        end
        ST_PREP: begin
          n_r    <= n_eff;
          step_r <= steps;
        end
        ST_SHIFT: begin
          step_r <= step_r - SPW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_byte    = out_read_byte_r;
  assign out_is_animating = out_is_animating_r;
  assign out_did_shift    = out_did_shift_r;
  assign out_bad_amount   = out_bad_amount_r;

  // a result follows either an accepted transaction or the end of busy work
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(accept) || $past(state_r != ST_IDLE)))
    else $error("result strobe without a transaction");

  // a shift in progress always has steps left
  a_shift_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (step_r != '0))
    else $error("shift state with no steps left");

  // a tick never both shifts and reports a bad amount
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_did_shift_r && out_bad_amount_r))
    else $error("did_shift and bad_amount together");

  // stop clears the animation
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_STOP)) |=> !animating_r)
    else $error("animation still running after stop");

  // shift work only happens while the animation runs
  a_shift_animating: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PREP) || (state_r == ST_SHIFT)) |-> animating_r)
    else $error("shift work while stopped");

endmodule

`default_nettype wire

// ----- sv/pixel_strip_timed_shifter.sv -----
// top level of the pixel strip timed shifter: sequencer and row of byte cells
`default_nettype none

// Usage
//   Input channel: a transaction (in_cmd, in_byte_index, in_byte_value) is taken
//   at a clock edge with start high and busy low. Commands: write byte, read
//   byte, start, stop and one millisecond tick.
//   Result channel: one result per transaction, shown for exactly one cycle
//   with out_valid high. The receiver cannot stall it.
//   Configuration: cfg_we with cfg_index and cfg_data writes a register at a
//   clock edge; write only while the block is idle.
// Store, busy and results
//   The pixel store is a row of MAX_PIXELS*MAX_BYTES_PER_PIXEL byte cells.
//   An in-range write or read rotates the whole row once past the head cell
//   while busy; the result is valid in the cycle in which busy falls.
//   A tick that shifts goes through ST_PREP and then ST_SHIFT for steps byte
//   moves, steps being shift_amount*bytes_per_pixel, or strip bytes minus
//   that for a forward rotation; the row moves one byte position per cycle.
//   Every other transaction gives its result the next cycle with busy low.
// Reset
//   Synchronous reset clears every store byte at once, stops the animation
//   and loads the register defaults; no clearing sweep is needed.

module pixel_strip_timed_shifter #(
  parameter int MAX_PIXELS          = 256,
  parameter int MAX_BYTES_PER_PIXEL = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [psts_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [psts_pkg::INDEX_W-1:0]   in_byte_index,
  input  wire logic [psts_pkg::BYTE_W-1:0]    in_byte_value,
  output logic                                out_valid,
  output logic      [psts_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                                out_is_animating,
  output logic                                out_did_shift,
  output logic                                out_bad_amount,
  input  wire logic                           cfg_we,
  input  wire logic [psts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [psts_pkg::CFG_W-1:0]     cfg_data
);
  import psts_pkg::*;

  localparam int StoreBytes = MAX_PIXELS * MAX_BYTES_PER_PIXEL;

  logic [BYTE_W-1:0] cell_q [StoreBytes];
  cell_ctl_t         ctl;

  // sequencer with timers and configuration
  psts_ctrl #(
    .MAX_PIXELS          (MAX_PIXELS),
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_byte_index    (in_byte_index),
    .in_byte_value    (in_byte_value),
    .out_valid        (out_valid),
    .out_read_byte    (out_read_byte),
    .out_is_animating (out_is_animating),
    .out_did_shift    (out_did_shift),
    .out_bad_amount   (out_bad_amount),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .head             (cell_q[0]),
    .ctl              (ctl)
  );

  // row of byte cells, each linked to both neighbors
  for (genvar g = 0; g < StoreBytes; g++) begin : g_cell
    logic [BYTE_W-1:0] left_d;
    logic [BYTE_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[g-1];
    end

    if (g == StoreBytes - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[g+1];
    end

    psts_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .from_left  (left_d),
      .from_right (right_d),
      .q          (cell_q[g])
    );
  end

endmodule

`default_nettype wire
